### rtl/core/sktc_pkg.sv
// ----------------------------------------------------------------------------
// sktc_pkg
// shared opcodes and field widths of the sorted key to code link table
// ----------------------------------------------------------------------------
package sktc_pkg;

   localparam int OP_W    = 3;
   localparam int NUM_W   = 47;
   localparam int IDX_W   = 10;
   localparam int POS_W   = 3;
   localparam int SLOT_W  = 11;
   localparam int COUNT_W = 4;

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
   localparam logic [OP_W-1:0] OP_READ   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

endpackage

### rtl/core/sktc_ram.sv
// ----------------------------------------------------------------------------
// sktc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sktc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/core/sorted_key_to_code_link_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_to_code_link_table_top
// sorted key table with per-key sorted code lists, driven by a sequencer
// ----------------------------------------------------------------------------
// One item is handled at a time; req_tready is high only while the sequencer
// is idle. Every key operation starts with a binary search through the key
// memory, each probe issuing a read and then comparing. When the key is found,
// add and remove walk the slot's code list through the code memory port.
// Adding a new key moves every later entry up one slot through each memory's
// single read port: first the keys and lengths, then the code rows of each
// moved entry, before the new key is written. Read, clear and unknown opcodes
// need no search. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sorted_key_to_code_link_table_top
   import sktc_pkg::*;
#(
   parameter int MAX_KEYS          = 1024,
   parameter int MAX_CODES_PER_KEY = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // plu_number, barcode_number, entry_index, list_position, zero fill
   input  logic [111:0] req_tdata,
   // opcode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // ok, full_res, slot_index, code_value, code_count
   output logic [63:0]  rsp_tdata
);

   localparam int KAW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int UW   = $clog2(MAX_KEYS + 1);
   localparam int LW   = $clog2(MAX_CODES_PER_KEY + 1);
   localparam int PW   = (MAX_CODES_PER_KEY > 1) ? $clog2(MAX_CODES_PER_KEY) : 1;
   localparam int CAW  = KAW + PW;
   localparam int CDEP = MAX_KEYS * (2 ** PW);

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_SRCH     = 16'h0002,
      S_SCMP     = 16'h0004,
      S_LEN      = 16'h0008,
      S_LSCAN_RD = 16'h0010,
      S_LSCAN_CK = 16'h0020,
      S_LMOVE_RD = 16'h0040,
      S_LMOVE_WR = 16'h0080,
      S_LDONE    = 16'h0100,
      S_KMOVE_RD = 16'h0200,
      S_KMOVE_WR = 16'h0400,
      S_CMOVE_RD = 16'h0800,
      S_CMOVE_WR = 16'h1000,
      S_NEWKEY   = 16'h2000,
      S_RDWAIT   = 16'h4000,
      S_FINISH   = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [NUM_W-1:0]   key_ff, key_in;
   logic [NUM_W-1:0]   code_ff, code_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [UW-1:0]      used_ff, used_in;
   logic [UW-1:0]      lo_ff, lo_in;
   logic [UW-1:0]      hi_ff, hi_in;
   logic [KAW-1:0]     mid_ff, mid_in;
   logic               hit_ff, hit_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      p_ff, p_in;
   logic [LW-1:0]      mv_ff, mv_in;
   logic [KAW-1:0]     kcnt_ff, kcnt_in;
   logic [CAW-1:0]     caddr_ff, caddr_in;
   logic               res_ok_ff, res_ok_in;
   logic               res_full_ff, res_full_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [NUM_W-1:0]   res_value_ff, res_value_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   logic               key_we, len_we, code_we;
   logic [KAW-1:0]     key_wa, key_ra, len_wa, len_ra;
   logic [NUM_W-1:0]   key_wd, key_rd, code_wd, code_rd;
   logic [LW-1:0]      len_wd, len_rd;
   logic [CAW-1:0]     code_wa, code_ra;

   logic [UW-1:0]      mid_full;
   logic [KAW-1:0]     slot_k;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mid_full = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign slot_k   = KAW'(lo_ff);

   sktc_ram #(.WIDTH(NUM_W), .DEPTH(MAX_KEYS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(key_ra), .rd_data(key_rd)
   );

   sktc_ram #(.WIDTH(LW), .DEPTH(MAX_KEYS)) u_len_ram (
      .clock(clock), .wr_en(len_we), .wr_addr(len_wa), .wr_data(len_wd),
      .rd_addr(len_ra), .rd_data(len_rd)
   );

   sktc_ram #(.WIDTH(NUM_W), .DEPTH(CDEP)) u_code_ram (
      .clock(clock), .wr_en(code_we), .wr_addr(code_wa), .wr_data(code_wd),
      .rd_addr(code_ra), .rd_data(code_rd)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      code_in      = code_ff;
      pos_in       = pos_ff;
      used_in      = used_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      hit_in       = hit_ff;
      len_in       = len_ff;
      p_in         = p_ff;
      mv_in        = mv_ff;
      kcnt_in      = kcnt_ff;
      caddr_in     = caddr_ff;
      res_ok_in    = res_ok_ff;
      res_full_in  = res_full_ff;
      res_slot_in  = res_slot_ff;
      res_value_in = res_value_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      key_we  = 1'b0;
      key_wa  = '0;
      key_wd  = '0;
      key_ra  = mid_full[KAW-1:0];
      len_we  = 1'b0;
      len_wa  = '0;
      len_wd  = '0;
      len_ra  = slot_k;
      code_we = 1'b0;
      code_wa = '0;
      code_wd = '0;
      code_ra = {slot_k, PW'(p_ff)};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser;
               key_in       = req_tdata[46:0];
               code_in      = req_tdata[93:47];
               pos_in       = req_tdata[106:104];
               lo_in        = '0;
               hi_in        = used_ff;
               hit_in       = 1'b0;
               res_ok_in    = 1'b0;
               res_full_in  = 1'b0;
               res_slot_in  = '0;
               res_value_in = '0;
               res_count_in = '0;
               case (req_tuser)
                  OP_ADD, OP_REMOVE, OP_FIND: begin
                     state_in = S_SRCH;
                  end
                  OP_READ: begin
                     res_slot_in = SLOT_W'(req_tdata[103:94]);
                     len_ra      = KAW'(req_tdata[103:94]);
                     code_ra     = {KAW'(req_tdata[103:94]), PW'(req_tdata[106:104])};
                     if (32'(req_tdata[103:94]) < 32'(used_ff)) begin
                        state_in = S_RDWAIT;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  OP_CLEAR: begin
                     used_in   = '0;
                     res_ok_in = 1'b1;
                     state_in  = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_full[KAW-1:0];
               state_in = S_SCMP;
            end else begin
               res_slot_in = SLOT_W'(lo_ff);
               if (hit_ff) begin
                  state_in = S_LEN;
               end else if (op_ff == OP_ADD) begin
                  if (32'(used_ff) >= MAX_KEYS) begin
                     res_full_in = 1'b1;
                     state_in    = S_FINISH;
                  end else if (used_ff > lo_ff) begin
                     kcnt_in  = KAW'(used_ff - 1'b1);
                     state_in = S_KMOVE_RD;
                  end else begin
                     state_in = S_NEWKEY;
                  end
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCMP: begin
            if (key_rd < key_ff) begin
               lo_in = UW'(mid_ff) + 1'b1;
            end else begin
               hi_in  = UW'(mid_ff);
               hit_in = (key_rd == key_ff);
            end
            state_in = S_SRCH;
         end
         S_LEN: begin
            len_in = len_rd;
            p_in   = '0;
            if (op_ff == OP_FIND) begin
               res_ok_in    = 1'b1;
               res_count_in = COUNT_W'(len_rd);
               state_in     = S_FINISH;
            end else begin
               state_in = S_LSCAN_RD;
            end
         end
         S_LSCAN_RD: begin
            if (p_ff < len_ff) begin
               state_in = S_LSCAN_CK;
            end else begin
               res_count_in = COUNT_W'(len_ff);
               if (op_ff == OP_ADD) begin
                  if (32'(len_ff) >= MAX_CODES_PER_KEY) begin
                     res_full_in = 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     mv_in    = len_ff;
                     state_in = S_LDONE;
                  end
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_LSCAN_CK: begin
            if (op_ff == OP_ADD) begin
               if (code_rd < code_ff) begin
                  p_in     = p_ff + 1'b1;
                  state_in = S_LSCAN_RD;
               end else if (code_rd == code_ff) begin
                  res_count_in = COUNT_W'(len_ff);
                  state_in     = S_FINISH;
               end else if (32'(len_ff) >= MAX_CODES_PER_KEY) begin
                  res_full_in  = 1'b1;
                  res_count_in = COUNT_W'(len_ff);
                  state_in     = S_FINISH;
               end else begin
                  mv_in    = len_ff;
                  state_in = S_LMOVE_RD;
               end
            end else begin
               if (code_rd == code_ff) begin
                  mv_in    = p_ff;
                  state_in = S_LMOVE_RD;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = S_LSCAN_RD;
               end
            end
         end
         S_LMOVE_RD: begin
            if (op_ff == OP_ADD) begin
               code_ra = {slot_k, PW'(mv_ff - 1'b1)};
               if (mv_ff > p_ff) begin
                  state_in = S_LMOVE_WR;
               end else begin
                  state_in = S_LDONE;
               end
            end else begin
               code_ra = {slot_k, PW'(mv_ff + 1'b1)};
               if (({1'b0, mv_ff} + 1'b1) < {1'b0, len_ff}) begin
                  state_in = S_LMOVE_WR;
               end else begin
                  state_in = S_LDONE;
               end
            end
         end
         S_LMOVE_WR: begin
            code_we = 1'b1;
            code_wa = {slot_k, PW'(mv_ff)};
            code_wd = code_rd;
            if (op_ff == OP_ADD) begin
               mv_in = mv_ff - 1'b1;
            end else begin
               mv_in = mv_ff + 1'b1;
            end
            state_in = S_LMOVE_RD;
         end
         S_LDONE: begin
            len_we    = 1'b1;
            len_wa    = slot_k;
            res_ok_in = 1'b1;
            if (op_ff == OP_ADD) begin
               code_we      = 1'b1;
               code_wa      = {slot_k, PW'(p_ff)};
               code_wd      = code_ff;
               len_wd       = len_ff + 1'b1;
               res_count_in = COUNT_W'(len_ff) + 1'b1;
            end else begin
               len_wd       = len_ff - 1'b1;
               res_count_in = COUNT_W'(len_ff) - 1'b1;
            end
            state_in = S_FINISH;
         end
         S_KMOVE_RD: begin
            key_ra   = kcnt_ff;
            len_ra   = kcnt_ff;
            state_in = S_KMOVE_WR;
         end
         S_KMOVE_WR: begin
            key_we = 1'b1;
            key_wa = kcnt_ff + 1'b1;
            key_wd = key_rd;
            len_we = 1'b1;
            len_wa = kcnt_ff + 1'b1;
            len_wd = len_rd;
            if (kcnt_ff == slot_k) begin
               caddr_in = {KAW'(used_ff - 1'b1), {PW{1'b1}}};
               state_in = S_CMOVE_RD;
            end else begin
               kcnt_in  = kcnt_ff - 1'b1;
               state_in = S_KMOVE_RD;
            end
         end
         S_CMOVE_RD: begin
            code_ra  = caddr_ff;
            state_in = S_CMOVE_WR;
         end
         S_CMOVE_WR: begin
            code_we = 1'b1;
            code_wa = caddr_ff + CAW'(2 ** PW);
            code_wd = code_rd;
            if (caddr_ff == {slot_k, {PW{1'b0}}}) begin
               state_in = S_NEWKEY;
            end else begin
               caddr_in = caddr_ff - 1'b1;
               state_in = S_CMOVE_RD;
            end
         end
         S_NEWKEY: begin
            key_we       = 1'b1;
            key_wa       = slot_k;
            key_wd       = key_ff;
            len_we       = 1'b1;
            len_wa       = slot_k;
            len_wd       = LW'(1);
            code_we      = 1'b1;
            code_wa      = {slot_k, {PW{1'b0}}};
            code_wd      = code_ff;
            used_in      = used_ff + 1'b1;
            res_ok_in    = 1'b1;
            res_count_in = COUNT_W'(1);
            state_in     = S_FINISH;
         end
         S_RDWAIT: begin
            res_count_in = COUNT_W'(len_rd);
            if (32'(pos_ff) < 32'(len_rd)) begin
               res_ok_in    = 1'b1;
               res_value_in = code_rd;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_count_ff, res_value_ff, res_slot_ff,
                               res_full_ff, res_ok_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      code_ff      <= code_in;
      pos_ff       <= pos_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      hit_ff       <= hit_in;
      len_ff       <= len_in;
      p_ff         <= p_in;
      mv_ff        <= mv_in;
      kcnt_ff      <= kcnt_in;
      caddr_ff     <= caddr_in;
      res_ok_ff    <= res_ok_in;
      res_full_ff  <= res_full_in;
      res_slot_ff  <= res_slot_in;
      res_value_ff <= res_value_in;
      res_count_ff <= res_count_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
